@@ rtl/mda_pkg.sv @@
// Shared types and constants for the multidimensional array access block.
`default_nettype none

package mda_pkg;

  // Number of index fields on the input word.
  localparam int PORT_DIMS = 4;
  // Width of one index field.
  localparam int IDX_W     = 4;
  // Width of one configured length, wide enough to hold a clamp of sixteen.
  localparam int LEN_W     = 5;
  // Width of the raw configuration data and raw length registers.
  localparam int CFG_W     = 4;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;
  // Width of the dimension count register.
  localparam int CNT_W     = 3;
  // Width of the dimension pointer.
  localparam int PTR_W     = 2;
  // Offset and stride width: a product of four lengths of up to sixteen.
  localparam int OFS_W     = 17;
  // Width of the element fields on the stream ports.
  localparam int VAL_W     = 16;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0] DIM_COUNT_RST = 3'd1;
  localparam logic [CFG_W-1:0] LENGTH_RST    = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_3  = 3'd4;

  // Access kinds carried in tuser.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Result status codes.
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_BAD = 1'b1;

  typedef logic [LEN_W-1:0]        len_t;
  typedef len_t [PORT_DIMS-1:0]    len_arr_t;
  typedef logic [IDX_W-1:0]        idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_ACCESS,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic access;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_dim;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/mda_cfg.sv @@
// Configuration registers with clamping of the dimension count and lengths.
`default_nettype none

module mda_cfg #(
  parameter int MAX_DIMS   = 4,
  parameter int MAX_LENGTH = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [mda_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [mda_pkg::CFG_W-1:0]        cfg_data_i,
  output logic [mda_pkg::CNT_W-1:0]             dims_o,
  output mda_pkg::len_arr_t                     lengths_o
);

  localparam int DimsCap = (MAX_DIMS < mda_pkg::PORT_DIMS) ? MAX_DIMS : mda_pkg::PORT_DIMS;

  logic [mda_pkg::CNT_W-1:0] dim_count_q, dim_count_d;
  logic [mda_pkg::PORT_DIMS-1:0][mda_pkg::CFG_W-1:0] length_q, length_d;

  // Writes are taken in every cycle.
  assign cfg_ready_o = 1'b1;

  // Register write decode; indexes beyond the list are dropped.
  always_comb begin
    dim_count_d = dim_count_q;
    length_d    = length_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mda_pkg::REG_DIM_COUNT: dim_count_d = cfg_data_i[mda_pkg::CNT_W-1:0];
        mda_pkg::REG_LENGTH_0:  length_d[0] = cfg_data_i;
        mda_pkg::REG_LENGTH_1:  length_d[1] = cfg_data_i;
        mda_pkg::REG_LENGTH_2:  length_d[2] = cfg_data_i;
        mda_pkg::REG_LENGTH_3:  length_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q <= mda_pkg::DIM_COUNT_RST;
      length_q    <= {mda_pkg::PORT_DIMS{mda_pkg::LENGTH_RST}};
    end else begin
      dim_count_q <= dim_count_d;
      length_q    <= length_d;
    end
  end

  // A count of zero means one dimension; counts above the cap are capped.
  always_comb begin
    if (dim_count_q == '0) begin
      dims_o = mda_pkg::CNT_W'(1);
    end else if (dim_count_q > mda_pkg::CNT_W'(DimsCap)) begin
      dims_o = mda_pkg::CNT_W'(DimsCap);
    end else begin
      dims_o = dim_count_q;
    end
  end

  // Lengths above the maximum are taken as the maximum.
  always_comb begin
    for (int k = 0; k < mda_pkg::PORT_DIMS; k++) begin
      if (mda_pkg::LEN_W'(length_q[k]) > mda_pkg::LEN_W'(MAX_LENGTH)) begin
        lengths_o[k] = mda_pkg::LEN_W'(MAX_LENGTH);
      end else begin
        lengths_o[k] = mda_pkg::LEN_W'(length_q[k]);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mda_ctrl.sv @@
// Controller state machine that sequences one access at a time.
`default_nettype none

module mda_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mda_pkg::dp_status_t  status_i,
  output mda_pkg::ctrl_cmd_t        cmd_o
);

  mda_pkg::ctrl_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mda_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mda_pkg::ST_STEP;
      end
      mda_pkg::ST_STEP: begin
        if (status_i.last_dim) state_d = mda_pkg::ST_ACCESS;
      end
      mda_pkg::ST_ACCESS: begin
        state_d = mda_pkg::ST_EMIT;
      end
      mda_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = mda_pkg::ST_IDLE;
      end
      default: state_d = mda_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Outputs.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      mda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      mda_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
      end
      mda_pkg::ST_ACCESS: begin
        cmd_o.access = 1'b1;
      end
      mda_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // An accepted word is followed by the first dimension step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> cmd_o.step)
    else $error("accepted word not followed by a dimension step");

  // The memory access comes right after the last dimension step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && status_i.last_dim) |=> cmd_o.access)
    else $error("memory access missing after last dimension");

  // No new word is taken while an access is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step || cmd_o.access) |-> !in_ready_o)
    else $error("input ready while an access is in flight");
`endif

endmodule

`default_nettype wire

@@ rtl/mda_dpath.sv @@
// Datapath: index checks, stride accumulation, element store and output register.
`default_nettype none

module mda_dpath #(
  parameter int ELEM_WIDTH  = 16,
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mda_pkg::ctrl_cmd_t            cmd_i,
  output mda_pkg::dp_status_t                status_o,
  input  wire logic [mda_pkg::CNT_W-1:0]     dims_i,
  input  wire mda_pkg::len_arr_t             lengths_i,
  input  wire logic                          action_i,
  input  wire logic [mda_pkg::PORT_DIMS*mda_pkg::IDX_W-1:0] indexes_i,
  input  wire logic [mda_pkg::VAL_W-1:0]     write_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               status_bit_o,
  output logic [mda_pkg::VAL_W-1:0]          read_value_o
);

  localparam int AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Latched access.
  logic                                  action_q;
  mda_pkg::idx_t [mda_pkg::PORT_DIMS-1:0] idx_q;
  logic [mda_pkg::VAL_W-1:0]             wvalue_q;

  // Walk state.
  logic [mda_pkg::PTR_W-1:0]  ptr_q, ptr_d;
  logic [mda_pkg::OFS_W-1:0]  offset_q, offset_d;
  logic [mda_pkg::OFS_W-1:0]  stride_q, stride_d;
  logic                       bad_q, bad_d;

  // Access result.
  logic                       fail_q;
  logic                       read_q;
  logic [ELEM_WIDTH-1:0]      rdata_q;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic                       out_status_q;
  logic [mda_pkg::VAL_W-1:0]  out_value_q;

  // Element store.
  logic [ELEM_WIDTH-1:0]      mem [STORE_DEPTH];

  mda_pkg::idx_t              cur_idx;
  mda_pkg::len_t              cur_len;
  logic                       in_store;
  logic                       access_ok;
  logic [AddrW-1:0]           addr;

  assign cur_idx   = idx_q[ptr_q];
  assign cur_len   = lengths_i[ptr_q];
  assign in_store  = offset_q < mda_pkg::OFS_W'(STORE_DEPTH);
  assign access_ok = !bad_q && in_store;
  assign addr      = offset_q[AddrW-1:0];

  assign status_o.last_dim = (ptr_q == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i;
      idx_q    <= indexes_i;
      wvalue_q <= write_value_i;
    end
  end

  // One dimension per step, innermost first: check the index, add its
  // weighted term and grow the stride by this length.
  always_comb begin
    ptr_d    = ptr_q;
    offset_d = offset_q;
    stride_d = stride_q;
    bad_d    = bad_q;
    if (cmd_i.load) begin
      ptr_d    = mda_pkg::PTR_W'(dims_i - mda_pkg::CNT_W'(1));
      offset_d = '0;
      stride_d = mda_pkg::OFS_W'(1);
      bad_d    = 1'b0;
    end else if (cmd_i.step) begin
      if (mda_pkg::LEN_W'(cur_idx) >= cur_len) begin
        bad_d = 1'b1;
      end else begin
        offset_d = offset_q + mda_pkg::OFS_W'(stride_q * cur_idx);
      end
      stride_d = mda_pkg::OFS_W'(stride_q * cur_len);
      if (ptr_q != '0) ptr_d = ptr_q - mda_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    stride_q <= stride_d;
    bad_q    <= bad_d;
  end

  // Element store: one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.access && access_ok) begin
      if (action_q == mda_pkg::ACT_WRITE) begin
        mem[addr] <= ELEM_WIDTH'(wvalue_q);
      end else begin
        rdata_q <= mem[addr];
      end
    end
  end

  // Access outcome, held until the result is handed over.
  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      fail_q <= !access_ok;
      read_q <= (action_q == mda_pkg::ACT_READ);
    end
  end

  // Output register parts the result from the next access.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= fail_q ? mda_pkg::STAT_BAD : mda_pkg::STAT_OK;
      out_value_q  <= (!fail_q && read_q) ? mda_pkg::VAL_W'(rdata_q) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_bit_o = out_status_q;
  assign read_value_o = out_value_q;

`ifndef ASSERT_OFF
  // A result is only loaded into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending word");

  // A failed access always reports zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == mda_pkg::STAT_BAD) |-> (out_value_q == '0))
    else $error("failed access carries data");

  // The walk starts at the innermost dimension in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (ptr_q == $past(mda_pkg::PTR_W'(dims_i - mda_pkg::CNT_W'(1)))))
    else $error("dimension walk did not start at the innermost dimension");
`endif

endmodule

`default_nettype wire

@@ rtl/multidim_array_access.sv @@
// Top level of the row-major multidimensional array access engine.
`default_nettype none

// Each input word is one read or write of an element store that is addressed
// as a row-major array of up to four dimensions, shaped by the dimension count
// and length registers. The engine handles one access at a time: an accepted
// word passes through the index walk, which checks one dimension and adds its
// stride term per cycle for each dimension in use, then the single-port store
// access, then the load of the output register, held until that register is
// free. The output register lets the next word be accepted while a result
// still waits downstream. An index at or above its length, or an offset
// beyond the store, gives status 1 and no access. Reading an element that was
// never written returns unspecified data. Register writes are taken at any
// time but must only be made while the engine is idle.
module multidim_array_access #(
  parameter int MAX_DIMS    = 4,
  parameter int MAX_LENGTH  = 8,
  parameter int ELEM_WIDTH  = 16,
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  // Access stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: index_0 [3:0], index_1 [7:4], index_2 [11:8], index_3 [15:12],
  //        write_value [31:16]
  input  wire logic [31:0] s_axis_tdata,
  // tuser: action [0]
  input  wire logic        s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: read_value [15:0]
  output logic [15:0]      m_axis_tdata,
  // tuser: status [0]
  output logic             m_axis_tuser
);

  logic [mda_pkg::CNT_W-1:0] dims;
  mda_pkg::len_arr_t         lengths;
  mda_pkg::ctrl_cmd_t        cmd;
  mda_pkg::dp_status_t       dp_status;

  mda_cfg #(
    .MAX_DIMS   (MAX_DIMS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dims_o      (dims),
    .lengths_o   (lengths)
  );

  mda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  mda_dpath #(
    .ELEM_WIDTH  (ELEM_WIDTH),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .dims_i        (dims),
    .lengths_i     (lengths),
    .action_i      (s_axis_tuser),
    .indexes_i     (s_axis_tdata[15:0]),
    .write_value_i (s_axis_tdata[31:16]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_bit_o  (m_axis_tuser),
    .read_value_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire
